[sv/cbl_pkg.sv]
// Shared types and constants for the charging breath LED sequencer.
// Used by every module of the block; depends on nothing.
package cbl_pkg;

	localparam int STEP_BITS_DEF = 10;
	localparam int TIME_BITS_DEF = 16;
	localparam int ADDR_BITS     = 5;

	localparam logic [2:0] REG_COLOR    = 3'd0;
	localparam logic [2:0] REG_STEPS    = 3'd1;
	localparam logic [2:0] REG_STEP_T   = 3'd2;
	localparam logic [2:0] REG_HOLD_T   = 3'd3;
	localparam logic [2:0] REG_FULL_LVL = 3'd4;

	typedef struct packed {
		logic       usb_powered;
		logic [6:0] charge_pct;
	} cbl_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       refresh;
	} cbl_out_t;

	typedef struct packed {
		logic [23:0] indicator_color;
		logic [9:0]  breath_steps;
		logic [15:0] step_ticks;
		logic [15:0] off_hold_ticks;
		logic [6:0]  full_level;
	} cbl_cfg_t;

	typedef struct packed {
		logic load;
		logic iter;
		logic div_step;
		logic div_last;
		logic out_load;
	} cbl_cmd_t;

	typedef struct packed {
		logic ticks_zero;
		logic show;
	} cbl_stat_t;

endpackage

[sv/charging_breath_led_sequencer_unit.sv]
// Top level of the charging breath LED sequencer: register port, controller, datapath.
// Depends on cbl_pkg, cbl_ctrl and cbl_datapath.
//
//  channel  direction  handshake                 payload
//  tick     in         tick_valid / tick_stall   cbl_in_t  (usb_powered, charge_pct)
//  led      out        led_valid / led_stall     cbl_out_t (red, green, blue, refresh)
//  cfg      in         psel/penable/pwrite       paddr, pwdata, prdata
//
// One request per tick, one result per request. A tick goes from the decision state to
// the result state, via the divider state when a new step is shown: the restoring
// divider that scales the three channels runs one quotient bit per cycle.
// Reset clears sequencer state to the hold phase with dark colour and registers to defaults.
// A stalled result waits in the output register; the next tick is taken meanwhile and
// finishes once the result slot frees.
module charging_breath_led_sequencer_unit
	import cbl_pkg::*;
#(
	parameter int STEP_BITS = STEP_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 tick_valid,
	output logic                 tick_stall,
	input  cbl_in_t              tick,
	output logic                 led_valid,
	input  logic                 led_stall,
	output cbl_out_t             led
);

	cbl_cfg_t  cfg_q;
	cbl_cmd_t  cmd;
	cbl_stat_t stat;
	logic      wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.indicator_color <= 24'hff0000;
			cfg_q.breath_steps    <= 10'd32;
			cfg_q.step_ticks      <= 16'd20;
			cfg_q.off_hold_ticks  <= 16'd500;
			cfg_q.full_level      <= 7'd95;
		end else if (wr) begin
			unique case (paddr[4:2])
				REG_COLOR:    cfg_q.indicator_color <= pwdata[23:0];
				REG_STEPS:    cfg_q.breath_steps    <= pwdata[9:0];
				REG_STEP_T:   cfg_q.step_ticks      <= pwdata[15:0];
				REG_HOLD_T:   cfg_q.off_hold_ticks  <= pwdata[15:0];
				REG_FULL_LVL: cfg_q.full_level      <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_COLOR:    prdata = 32'(cfg_q.indicator_color);
			REG_STEPS:    prdata = 32'(cfg_q.breath_steps);
			REG_STEP_T:   prdata = 32'(cfg_q.step_ticks);
			REG_HOLD_T:   prdata = 32'(cfg_q.off_hold_ticks);
			REG_FULL_LVL: prdata = 32'(cfg_q.full_level);
			default:      prdata = 32'd0;
		endcase
	end

	cbl_ctrl #(
		.STEP_BITS(STEP_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.led_valid (led_valid),
		.led_stall (led_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cbl_datapath #(
		.STEP_BITS(STEP_BITS),
		.TIME_BITS(TIME_BITS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.tick  (tick),
		.cmd   (cmd),
		.stat  (stat),
		.led   (led)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall |=> tick_stall)
		else $error("request accepted while the sequencer stayed open");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(cmd.iter || cmd.div_step || cmd.out_load))
		else $error("load overlaps other commands");

	a_div_follows_show: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.iter && stat.show |=> cmd.div_step)
		else $error("divider did not start after a new step");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> led_valid)
		else $error("result register loaded but not presented");

endmodule

[sv/cbl_ctrl.sv]
// Sequencer controller: tick acceptance, decision loop, divider count, result slot.
// Depends on cbl_pkg; drives commands into cbl_datapath.
module cbl_ctrl
	import cbl_pkg::*;
#(
	parameter int STEP_BITS = STEP_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tick_valid,
	output logic      tick_stall,
	output logic      led_valid,
	input  logic      led_stall,
	input  cbl_stat_t stat,
	output cbl_cmd_t  cmd
);

	localparam int DIV_STEPS = 8 + STEP_BITS;
	localparam int CW = $clog2(DIV_STEPS);
	localparam logic [CW-1:0] DIV_LAST = CW'(DIV_STEPS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]    state_q, state_nx;
	logic [CW-1:0] cnt_q;
	logic          led_valid_q;

	always_comb begin
		cmd = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (tick_valid) begin
					cmd.load = 1'b1;
					state_nx = S_RUN;
				end
			end
			S_RUN: begin
				if (stat.ticks_zero) begin
					cmd.iter = 1'b1;
					if (stat.show) state_nx = S_DIV;
				end else begin
					state_nx = S_FIN;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					cmd.div_last = 1'b1;
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				if (!led_valid_q || !led_stall) begin
					cmd.out_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			led_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.iter) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + 1'b1;
			led_valid_q <= cmd.out_load | (led_valid_q & led_stall);
		end
	end

	assign tick_stall = (state_q != S_IDLE);
	assign led_valid  = led_valid_q;

endmodule

[sv/cbl_datapath.sv]
// Sequencer datapath: phase, step and tick counters, scaling divider, result register.
// Depends on cbl_pkg; steered by cbl_ctrl.
module cbl_datapath
	import cbl_pkg::*;
#(
	parameter int STEP_BITS = STEP_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cbl_cfg_t  cfg,
	input  cbl_in_t   tick,
	input  cbl_cmd_t  cmd,
	output cbl_stat_t stat,
	output cbl_out_t  led
);

	localparam int W = 8 + STEP_BITS;
	localparam logic [1:0] PH_HOLD = 2'd0;
	localparam logic [1:0] PH_UP   = 2'd1;
	localparam logic [1:0] PH_DOWN = 2'd2;
	localparam logic [1:0] PH_IDLE = 2'd3;
	localparam logic [16:0] STEP_MAX_X = 17'((64'd1 << STEP_BITS) - 64'd1);
	localparam logic [32:0] TIME_MAX_X = 33'((64'd1 << TIME_BITS) - 64'd1);

	logic [1:0]           phase_q;
	logic [STEP_BITS-1:0] step_q, idle_q;
	logic [TIME_BITS-1:0] ticks_q;
	logic [23:0]          shown_q;
	logic                 refresh_q, charging_q;
	logic [W-1:0]         quo_q [3];
	logic [STEP_BITS-1:0] rem_q [3];
	cbl_out_t             led_q;

	logic [16:0]          n_x;
	logic [32:0]          st_x, ht_x;
	logic [STEP_BITS-1:0] n, show_s, s_clamp;
	logic [TIME_BITS-1:0] est, hold_t;
	logic [STEP_BITS:0]   step_inc;
	logic [1:0]           show_ph;
	logic                 show, do_hold, do_idle, do_idle_dec;
	logic [7:0]           chan [3];
	logic [W-1:0]         quo_ld [3], quo_nx [3];
	logic [STEP_BITS:0]   rem_sh [3];
	logic [STEP_BITS-1:0] rem_nx [3];
	logic                 ge [3];

	always_comb begin
		n_x = (cfg.breath_steps == 10'd0) ? 17'd1 :
			((17'(cfg.breath_steps) > STEP_MAX_X) ? STEP_MAX_X : 17'(cfg.breath_steps));
		n = n_x[STEP_BITS-1:0];
		st_x = (cfg.step_ticks == 16'd0) ? 33'd1 : 33'(cfg.step_ticks);
		if (st_x > TIME_MAX_X) st_x = TIME_MAX_X;
		est = st_x[TIME_BITS-1:0];
		ht_x = 33'(cfg.off_hold_ticks);
		if (ht_x > TIME_MAX_X) ht_x = TIME_MAX_X;
		hold_t = ht_x[TIME_BITS-1:0];
	end

	always_comb begin
		step_inc    = {1'b0, step_q} + 1'b1;
		show        = 1'b0;
		show_ph     = PH_UP;
		show_s      = '0;
		do_hold     = 1'b0;
		do_idle     = 1'b0;
		do_idle_dec = 1'b0;
		unique case (phase_q)
			PH_HOLD, PH_IDLE: begin
				if (phase_q == PH_IDLE && idle_q != '0) do_idle_dec = 1'b1;
				else if (!charging_q) do_idle = 1'b1;
				else show = 1'b1;
			end
			PH_UP: begin
				if (!charging_q) begin
					do_hold = 1'b1;
				end else if (step_inc <= {1'b0, n}) begin
					show = 1'b1;
					show_s = step_inc[STEP_BITS-1:0];
				end else begin
					show = 1'b1;
					show_ph = PH_DOWN;
					show_s = n - 1'b1;
				end
			end
			PH_DOWN: begin
				if (step_q == '0 || !charging_q) begin
					do_hold = 1'b1;
				end else begin
					show = 1'b1;
					show_ph = PH_DOWN;
					show_s = step_q - 1'b1;
				end
			end
		endcase
		s_clamp = (show_s > n) ? n : show_s;
	end

	always_comb begin
		chan[0] = cfg.indicator_color[23:16];
		chan[1] = cfg.indicator_color[15:8];
		chan[2] = cfg.indicator_color[7:0];
		for (int i = 0; i < 3; i++) begin
			quo_ld[i] = W'(chan[i]) * W'(s_clamp);
			rem_sh[i] = {rem_q[i], quo_q[i][W-1]};
			ge[i]     = (rem_sh[i] >= {1'b0, n});
			rem_nx[i] = ge[i] ? STEP_BITS'(rem_sh[i] - {1'b0, n}) : rem_sh[i][STEP_BITS-1:0];
			quo_nx[i] = {quo_q[i][W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HOLD;
			step_q     <= '0;
			idle_q     <= '0;
			ticks_q    <= '0;
			shown_q    <= '0;
			refresh_q  <= 1'b0;
			charging_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				charging_q <= tick.usb_powered && (tick.charge_pct != 7'd0)
					&& (tick.charge_pct < cfg.full_level);
				refresh_q <= 1'b0;
				if (ticks_q != '0) ticks_q <= ticks_q - 1'b1;
			end
			if (cmd.iter) begin
				if (do_idle_dec) begin
					idle_q  <= idle_q - 1'b1;
					ticks_q <= est;
				end else begin
					refresh_q <= 1'b1;
				end
				if (do_idle) begin
					shown_q <= '0;
					phase_q <= PH_IDLE;
					idle_q  <= n - 1'b1;
					ticks_q <= est;
				end
				if (do_hold) begin
					shown_q <= '0;
					phase_q <= PH_HOLD;
					ticks_q <= hold_t;
				end
				if (show) begin
					phase_q <= show_ph;
					step_q  <= show_s;
					ticks_q <= est;
				end
			end
			if (cmd.div_last) shown_q <= {quo_nx[0][7:0], quo_nx[1][7:0], quo_nx[2][7:0]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cmd.iter && show) begin
				quo_q[i] <= quo_ld[i];
				rem_q[i] <= '0;
			end else if (cmd.div_step) begin
				quo_q[i] <= quo_nx[i];
				rem_q[i] <= rem_nx[i];
			end
		end
		if (cmd.out_load) begin
			led_q.red     <= shown_q[23:16];
			led_q.green   <= shown_q[15:8];
			led_q.blue    <= shown_q[7:0];
			led_q.refresh <= refresh_q;
		end
	end

	assign stat.ticks_zero = (ticks_q == '0);
	assign stat.show       = show;
	assign led             = led_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for charging_breath_led_sequencer_unit: drives millisecond ticks
// and APB register writes, predicts every LED result and compares it field by field.
// Depends on cbl_pkg and the RTL of the block only.
module tb_top;
	import cbl_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_PRINTS    = 40;

	typedef enum logic [1:0] {
		SEQ_DARK_HOLD,
		SEQ_RAMP_UP,
		SEQ_RAMP_DOWN,
		SEQ_IDLE_WAIT
	} seq_phase_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 tick_valid = 1'b0;
	logic                 tick_stall;
	cbl_in_t              tick_req = '0;
	logic                 led_valid;
	logic                 led_stall = 1'b0;
	cbl_out_t             led_rsp;

	// register copy, reset values
	logic [23:0] cfg_color  = 24'hff0000;
	logic [9:0]  cfg_steps  = 10'd32;
	logic [15:0] cfg_step_t = 16'd20;
	logic [15:0] cfg_hold_t = 16'd500;
	logic [6:0]  cfg_full   = 7'd95;

	// sequencer copy
	seq_phase_e  seq_phase = SEQ_DARK_HOLD;
	int          seq_step = 0;
	int          seq_ticks = 0;
	int          seq_idle_chunks = 0;
	logic [23:0] seq_color = '0;

	cbl_out_t led_expect_q[$];
	int       mismatch_count = 0;
	int       ticks_sent = 0;
	int       leds_checked = 0;
	int       tick_gap_pct = 0;
	int       led_stall_pct = 0;
	int       stall_burst = 0;

	charging_breath_led_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick      (tick_req),
		.led_valid (led_valid),
		.led_stall (led_stall),
		.led       (led_rsp)
	);

	always #6 clk = ~clk;

	task automatic show_level(input seq_phase_e p, input int s, input int n, input int st);
		int lvl;
		int r;
		int g;
		int b;
		seq_phase = p;
		seq_step = s;
		lvl = (s > n) ? n : s;
		r = int'(cfg_color[23:16]) * lvl / n;
		g = int'(cfg_color[15:8]) * lvl / n;
		b = int'(cfg_color[7:0]) * lvl / n;
		seq_color = {r[7:0], g[7:0], b[7:0]};
		seq_ticks = st;
	endtask

	task automatic go_dark_hold();
		seq_color = '0;
		seq_phase = SEQ_DARK_HOLD;
		seq_ticks = int'(cfg_hold_t);
	endtask

	task automatic predict_led(input cbl_in_t t);
		int       n;
		int       st;
		bit       charging;
		bit       refresh;
		cbl_out_t e;
		n = (cfg_steps == 0) ? 1 : int'(cfg_steps);
		st = (cfg_step_t == 0) ? 1 : int'(cfg_step_t);
		charging = t.usb_powered && t.charge_pct != 0 && t.charge_pct < cfg_full;
		refresh = 1'b0;
		if (seq_ticks != 0)
			seq_ticks--;
		while (seq_ticks == 0) begin
			if (seq_phase == SEQ_IDLE_WAIT && seq_idle_chunks != 0) begin
				seq_idle_chunks--;
				seq_ticks = st;
			end else if (seq_phase == SEQ_DARK_HOLD || seq_phase == SEQ_IDLE_WAIT) begin
				refresh = 1'b1;
				if (!charging) begin
					seq_color = '0;
					seq_phase = SEQ_IDLE_WAIT;
					seq_idle_chunks = n - 1;
					seq_ticks = st;
				end else begin
					show_level(SEQ_RAMP_UP, 0, n, st);
				end
			end else if (seq_phase == SEQ_RAMP_UP) begin
				refresh = 1'b1;
				if (!charging)
					go_dark_hold();
				else if (seq_step + 1 <= n)
					show_level(SEQ_RAMP_UP, seq_step + 1, n, st);
				else
					show_level(SEQ_RAMP_DOWN, n - 1, n, st);
			end else begin
				refresh = 1'b1;
				if (seq_step == 0 || !charging)
					go_dark_hold();
				else
					show_level(SEQ_RAMP_DOWN, seq_step - 1, n, st);
			end
		end
		e.red = seq_color[23:16];
		e.green = seq_color[15:8];
		e.blue = seq_color[7:0];
		e.refresh = refresh;
		led_expect_q.push_back(e);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < MAX_PRINTS)
			$display("%0t: LED %s got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// receiver stall, with long hold-off on request
	always @(negedge clk) begin
		if (stall_burst > 0) begin
			led_stall = 1'b1;
			stall_burst--;
		end else begin
			led_stall = ($urandom_range(99) < led_stall_pct);
		end
	end

	always @(posedge clk) begin
		cbl_out_t w;
		if (arst_n && led_valid && !led_stall) begin
			if (led_expect_q.size() == 0) begin
				report_mismatch("result with no request pending", 1, 0);
			end else begin
				w = led_expect_q.pop_front();
				leds_checked++;
				if (led_rsp.red !== w.red)
					report_mismatch("red", int'(led_rsp.red), int'(w.red));
				if (led_rsp.green !== w.green)
					report_mismatch("green", int'(led_rsp.green), int'(w.green));
				if (led_rsp.blue !== w.blue)
					report_mismatch("blue", int'(led_rsp.blue), int'(w.blue));
				if (led_rsp.refresh !== w.refresh)
					report_mismatch("refresh", int'(led_rsp.refresh), int'(w.refresh));
			end
		end
	end

	// call at a falling edge; returns at a falling edge with valid still high
	task automatic send_tick(input logic usb, input logic [6:0] lvl);
		while ($urandom_range(99) < tick_gap_pct) begin
			tick_valid = 1'b0;
			@(negedge clk);
		end
		tick_valid = 1'b1;
		tick_req.usb_powered = usb;
		tick_req.charge_pct = lvl;
		do @(posedge clk); while (tick_stall);
		predict_led(tick_req);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic await_led_drain();
		tick_valid = 1'b0;
		while (led_expect_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_COLOR:    cfg_color = val[23:0];
			REG_STEPS:    cfg_steps = val[9:0];
			REG_STEP_T:   cfg_step_t = val[15:0];
			REG_HOLD_T:   cfg_hold_t = val[15:0];
			REG_FULL_LVL: cfg_full = val[6:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [23:0] color, input logic [9:0] steps,
			input logic [15:0] step_t, input logic [15:0] hold_t, input logic [6:0] full);
		cfg_write(REG_COLOR, {8'h00, color});
		cfg_write(REG_STEPS, {22'h0, steps});
		cfg_write(REG_STEP_T, {16'h0, step_t});
		cfg_write(REG_HOLD_T, {16'h0, hold_t});
		cfg_write(REG_FULL_LVL, {25'h0, full});
	endtask

	task automatic test_reset_defaults();
		send_tick(1'b1, 7'd50);
		for (int i = 0; i < 19; i++)
			send_tick(i[0], (i == 18) ? 7'd100 : 7'(i * 5));
		await_led_drain();
		cfg_write(REG_STEP_T, 32'd1);
		send_tick(1'b1, 7'd94);
	endtask

	task automatic test_ramp_and_abort();
		await_led_drain();
		set_config(24'hffffff, 10'd2, 16'd1, 16'd0, 7'd100);
		repeat (4) send_tick(1'b1, 7'd99);
		send_tick(1'b1, 7'd100);
		repeat (3) send_tick(1'b1, 7'd1);
		send_tick(1'b0, 7'd50);
	endtask

	task automatic test_degenerate_config();
		await_led_drain();
		set_config(24'h0180fe, 10'd0, 16'd0, 16'd1, 7'd127);
		repeat (4) send_tick(1'b1, 7'd100);
		await_led_drain();
		cfg_write(REG_FULL_LVL, 32'd0);
		send_tick(1'b1, 7'd50);
		send_tick(1'b1, 7'd0);
	endtask

	task automatic test_stale_steps();
		await_led_drain();
		set_config(24'h000000, 10'd6, 16'd1, 16'd2, 7'd100);
		cfg_write(REG_COLOR, 32'h00c35a17);
		repeat (9) send_tick(1'b1, 7'd60);
		await_led_drain();
		cfg_write(REG_STEPS, 32'd2);
		repeat (2) send_tick(1'b1, 7'd60);
	endtask

	task automatic test_random_breaths();
		logic [23:0] color;
		logic [9:0]  steps;
		logic [6:0]  full;
		int          noise_pct;
		int          top_lvl;
		int          pick;
		for (int p = 0; p < 12; p++) begin
			tick_gap_pct = (p < 4) ? 18 : (p < 8) ? 53 : 0;
			led_stall_pct = (p < 4) ? 53 : (p < 8) ? 18 : 0;
			await_led_drain();
			pick = $urandom_range(99);
			color = (pick < 10) ? 24'hffffff : (pick < 15) ? 24'h0 : 24'($urandom);
			pick = $urandom_range(99);
			steps = (pick < 8) ? 10'd0 : (pick < 16) ? 10'($urandom_range(1023, 512))
				: 10'($urandom_range(6, 1));
			full = ($urandom_range(99) < 8) ? 7'($urandom_range(127, 101))
				: 7'($urandom_range(100, 2));
			set_config(color, steps, 16'($urandom_range(3)), 16'($urandom_range(6)), full);
			// long ramps only survive with a steady charging input
			noise_pct = (steps >= 10'd512) ? 0 : 15;
			top_lvl = (full > 7'd100) ? 100 : int'(full) - 1;
			if (p == 9)
				stall_burst = 400;
			for (int i = 0; i < 82; i++) begin
				if ($urandom_range(99) < noise_pct)
					send_tick(1'($urandom_range(1)), 7'($urandom_range(100)));
				else
					send_tick(1'b1, 7'($urandom_range(top_lvl, 1)));
			end
		end
	endtask

	task automatic test_extreme_times();
		await_led_drain();
		set_config(24'hffffff, 10'd1, 16'd1, 16'd0, 7'd100);
		repeat (20) send_tick(1'b1, 7'd50);
		await_led_drain();
		set_config(24'hffffff, 10'd1023, 16'd65535, 16'd65535, 7'd100);
		repeat (3) send_tick(1'b1, 7'd99);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		tick_gap_pct = 18;
		led_stall_pct = 53;
		test_reset_defaults();
		test_ramp_and_abort();
		test_degenerate_config();
		test_stale_steps();
		test_random_breaths();
		tick_gap_pct = 0;
		led_stall_pct = 0;
		test_extreme_times();
		await_led_drain();
		$display("Covered: %0d ticks, %0d LED results, reset values, ramps, aborts, idle waits,",
			ticks_sent, leds_checked);
		$display("  zero and maximal register values, stale steps and a long output hold-off");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("Timeout with %0d results pending", led_expect_q.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
sv/cbl_pkg.sv
sv/cbl_ctrl.sv
sv/cbl_datapath.sv
sv/charging_breath_led_sequencer_unit.sv
tb/sv/tb_top.sv
